@@ design/kpt_pkg.sv @@
`default_nettype none
package kpt_pkg;
  localparam int unsigned MatW    = 18;
  localparam int unsigned SampleW = 16;
  localparam int unsigned ValueW  = 27;
  localparam int unsigned IndexW  = 5;
  localparam logic [MatW-1:0] MatReset = 18'd86593;

  typedef struct packed {
    logic [MatW-1:0] mat;
  } job_t;

  // product mod 3 of two coefficients in 0..2
  function automatic logic [1:0] mul3(input logic [1:0] a, input logic [1:0] b);
    logic [3:0] p;
    p = {2'b00, a} * {2'b00, b};
    case (p)
      4'd0: mul3 = 2'd0;
      4'd1: mul3 = 2'd1;
      4'd2: mul3 = 2'd2;
      4'd4: mul3 = 2'd1;
      default: mul3 = 2'd0;
    endcase
  endfunction

  // matrix entry (r,c), code 3 reads as 0
  function automatic logic [1:0] entry(input logic [MatW-1:0] m, input logic [1:0] r,
                                       input logic [1:0] c);
    logic [1:0] v;
    logic [3:0] k;
    k = {1'b0, r, 1'b0} + {2'b00, r} + {2'b00, c};
    v = m[{k, 1'b0} +: 2];
    entry = (v == 2'd3) ? 2'd0 : v;
  endfunction

  // base-3 digits of an index below 27, digit 0 in the low bits
  function automatic logic [5:0] digits3(input logic [IndexW-1:0] x);
    logic [IndexW-1:0] r;
    logic [1:0] d2, d1;
    if (x >= 5'd18) begin
      d2 = 2'd2; r = x - 5'd18;
    end else if (x >= 5'd9) begin
      d2 = 2'd1; r = x - 5'd9;
    end else begin
      d2 = 2'd0; r = x;
    end
    if (r >= 5'd6) begin
      d1 = 2'd2; r = r - 5'd6;
    end else if (r >= 5'd3) begin
      d1 = 2'd1; r = r - 5'd3;
    end else begin
      d1 = 2'd0;
    end
    digits3 = {d2, d1, r[1:0]};
  endfunction
endpackage
`default_nettype wire

@@ design/kronecker_power_transform_mod3_unit.sv @@
`default_nettype none
// each result takes one read per sample of the vector, then a drain state
// throughput: one sample per cycle while loading and busy is low; the next vector loads while one is
// computed, after that loading stalls until the single shared mac takes the held job
// reset: asynchronous active low, clears load count, queue and matrix to default
// results are strobed for one cycle; the receiver cannot stall
module kronecker_power_transform_mod3_unit #(
  parameter int unsigned DEPTH = 3
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic signed [15:0]           sample_i,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [17:0]                  cfg_data_i,
  output logic                              valid_o,
  output logic [4:0]                        out_index_o,
  output logic signed [26:0]                out_value_o,
  output logic                              last_o
);
  localparam int unsigned N = (DEPTH == 1) ? 3 : (DEPTH == 2) ? 9 : 27;
  logic [17:0] mat_q;
  // sample memory, double buffered by vector
  logic [15:0] mem_q [2][N];
  logic bank_w_q, bank_r_q;
  logic [4:0] wa, ra;
  logic we, push, pop, full_q;
  kpt_pkg::job_t job, qjob_q;
  logic [15:0] rdata_q;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) mat_q <= kpt_pkg::MatReset;
    else if (cfg_valid_i) mat_q <= cfg_data_i;
  end

  kpt_front #(.N(N)) u_front (
    .clk_i, .rst_ni, .start_i(start), .mat_i(mat_q),
    .q_full_i(full_q), .busy_o(busy), .push_o(push), .job_o(job),
    .wr_addr_o(wa), .wr_en_o(we));

  // one-entry job queue; a held job locks its bank, so loading stalls
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0; bank_w_q <= 1'b0; bank_r_q <= 1'b0; qjob_q <= '0;
    end else begin
      if (push) begin full_q <= 1'b1; qjob_q <= job; bank_w_q <= ~bank_w_q; end
      else if (pop) begin full_q <= 1'b0; bank_r_q <= bank_w_q ^ 1'b1; end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[bank_w_q][wa[$clog2(N)-1:0]] <= sample_i;
    rdata_q <= mem_q[bank_r_q][ra[$clog2(N)-1:0]];
  end

  kpt_back #(.N(N), .D(DEPTH)) u_back (
    .clk_i, .rst_ni, .q_valid_i(full_q), .job_i(qjob_q), .pop_o(pop),
    .rd_addr_o(ra), .rd_data_i(rdata_q), .valid_o, .out_index_o, .out_value_o,
    .last_o);
endmodule
`default_nettype wire

@@ design/kpt_front.sv @@
`default_nettype none
module kpt_front #(
  parameter int unsigned N = 27
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [kpt_pkg::MatW-1:0]     mat_i,
  input  wire logic                         q_full_i,
  output logic                              busy_o,
  output logic                              push_o,
  output kpt_pkg::job_t                     job_o,
  output logic [kpt_pkg::IndexW-1:0]        wr_addr_o,
  output logic                              wr_en_o
);
  logic [kpt_pkg::IndexW-1:0] cnt_q, cnt_d;
  logic acc;
  assign busy_o = q_full_i;
  assign acc = start_i & ~busy_o;
  assign wr_en_o = acc;
  assign wr_addr_o = cnt_q;
  assign push_o = acc && (cnt_q == kpt_pkg::IndexW'(N - 1));
  assign job_o.mat = mat_i;
  always_comb begin
    cnt_d = cnt_q;
    if (acc) cnt_d = push_o ? '0 : cnt_q + 1'b1;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= '0;
    else cnt_q <= cnt_d;
  end
endmodule
`default_nettype wire

@@ design/kpt_back.sv @@
`default_nettype none
module kpt_back #(
  parameter int unsigned N = 27,
  parameter int unsigned D = 3
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          q_valid_i,
  input  kpt_pkg::job_t                      job_i,
  output logic                               pop_o,
  output logic [kpt_pkg::IndexW-1:0]         rd_addr_o,
  input  wire logic [kpt_pkg::SampleW-1:0]   rd_data_i,
  output logic                               valid_o,
  output logic [kpt_pkg::IndexW-1:0]         out_index_o,
  output logic signed [kpt_pkg::ValueW-1:0]  out_value_o,
  output logic                               last_o
);
  typedef enum logic [1:0] {Idle, Run, Drain} state_e;
  state_e state_q;
  logic [kpt_pkg::IndexW-1:0] i_q, j_q;
  logic [kpt_pkg::IndexW-1:0] jr_q;
  logic rv_q, rlast_q;
  logic signed [kpt_pkg::ValueW-1:0] acc_q;
  logic [kpt_pkg::MatW-1:0] mat_q;
  logic [1:0] c;

  assign rd_addr_o = j_q;
  assign pop_o = (state_q == Idle) && q_valid_i;

  // coefficient for (i, jr) over all digits
  always_comb begin
    logic [5:0] da, db;
    da = kpt_pkg::digits3(i_q);
    db = kpt_pkg::digits3(jr_q);
    c = 2'd1;
    for (int d = 0; d < int'(D); d++) begin
      c = kpt_pkg::mul3(c, kpt_pkg::entry(mat_q, da[2*d +: 2], db[2*d +: 2]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= Idle; i_q <= '0; j_q <= '0; jr_q <= '0; rv_q <= 1'b0;
      rlast_q <= 1'b0; valid_o <= 1'b0; acc_q <= '0; mat_q <= '0;
      out_index_o <= '0; out_value_o <= '0; last_o <= 1'b0;
    end else begin
      valid_o <= 1'b0;
      rv_q <= 1'b0;
      case (state_q)
        Idle: if (q_valid_i) begin
          mat_q <= job_i.mat; i_q <= '0; j_q <= '0; acc_q <= '0; state_q <= Run;
        end
        Run: begin
          rv_q <= 1'b1; jr_q <= j_q;
          rlast_q <= (j_q == kpt_pkg::IndexW'(N - 1));
          j_q <= (j_q == kpt_pkg::IndexW'(N - 1)) ? '0 : j_q + 1'b1;
          if (j_q == kpt_pkg::IndexW'(N - 1)) state_q <= Drain;
        end
        Drain: ;
        default: state_q <= Idle;
      endcase
      if (rv_q) begin
        logic signed [kpt_pkg::ValueW-1:0] t;
        t = acc_q;
        if (c == 2'd1) t = t + kpt_pkg::ValueW'(signed'(rd_data_i));
        else if (c == 2'd2) t = t + (kpt_pkg::ValueW'(signed'(rd_data_i)) <<< 1);
        if (rlast_q) begin
          valid_o <= 1'b1; out_index_o <= i_q; out_value_o <= t;
          last_o <= (i_q == kpt_pkg::IndexW'(N - 1));
          acc_q <= '0;
          if (i_q == kpt_pkg::IndexW'(N - 1)) state_q <= Idle;
          else begin i_q <= i_q + 1'b1; state_q <= Run; end
        end else acc_q <= t;
      end
    end
  end
endmodule
`default_nettype wire

@@ sim/tb_top.sv @@
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned VecLen = 27;

  // matrix codes that give notable coefficient sets
  localparam logic [kpt_pkg::MatW-1:0] MatAllZeroCode = 18'h3FFFF;  // every code 3, reads as 0
  localparam logic [kpt_pkg::MatW-1:0] MatAllOne      = 18'h15555;
  localparam logic [kpt_pkg::MatW-1:0] MatAllTwo      = 18'h2AAAA;
  localparam logic [kpt_pkg::MatW-1:0] MatCleared     = 18'h00000;
  localparam logic [kpt_pkg::MatW-1:0] MatIdentity    = 18'h10101;

  typedef struct {
    logic [kpt_pkg::IndexW-1:0]        idx;
    logic signed [kpt_pkg::ValueW-1:0] value;
    logic                              last;
  } element_t;

  logic                               clk_i = 1'b0;
  logic                               rst_ni = 1'b0;
  logic                               start = 1'b0;
  logic                               busy;
  logic signed [kpt_pkg::SampleW-1:0] sample_i = '0;
  logic                               cfg_valid_i = 1'b0;
  logic                               cfg_ready_o;
  logic [kpt_pkg::MatW-1:0]           cfg_data_i = '0;
  logic                               valid_o;
  logic [kpt_pkg::IndexW-1:0]         out_index_o;
  logic signed [kpt_pkg::ValueW-1:0]  out_value_o;
  logic                               last_o;

  // shadow state of the transform
  logic [kpt_pkg::MatW-1:0]           cur_mat;
  logic signed [kpt_pkg::SampleW-1:0] loaded[VecLen];
  int unsigned                        load_cnt;

  element_t                           pending_elems[$];
  int unsigned                        fails = 0;
  bit                                 gaps_on = 1'b1;

  kronecker_power_transform_mod3_unit #(.DEPTH(3)) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .sample_i    (sample_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .valid_o     (valid_o),
    .out_index_o (out_index_o),
    .out_value_o (out_value_o),
    .last_o      (last_o)
  );

  always #6 clk_i = ~clk_i;

  // base matrix entry, code 3 reads as 0
  function automatic int unsigned mat_coef(logic [kpt_pkg::MatW-1:0] m, int unsigned r,
                                           int unsigned c);
    int unsigned v;
    v = (m >> (2 * (3 * r + c))) & 3;
    return (v == 3) ? 0 : v;
  endfunction

  // coefficient of the kronecker power: product mod 3 over the base-3 digits
  function automatic int unsigned kron_coef(logic [kpt_pkg::MatW-1:0] m, int unsigned i,
                                            int unsigned j);
    int unsigned p;
    p = 1;
    for (int d = 0; d < 3; d++) begin
      p = (p * mat_coef(m, i % 3, j % 3)) % 3;
      i = i / 3;
      j = j / 3;
    end
    return p;
  endfunction

  // queue the whole transformed vector once the last sample is in
  function automatic void transform_vector();
    element_t e;
    longint   acc;
    for (int unsigned i = 0; i < VecLen; i++) begin
      acc = 0;
      for (int unsigned j = 0; j < VecLen; j++)
        acc += longint'(kron_coef(cur_mat, i, j)) * longint'(loaded[j]);
      e.idx   = i[kpt_pkg::IndexW-1:0];
      e.value = acc[kpt_pkg::ValueW-1:0];
      e.last  = (i == VecLen - 1);
      pending_elems.push_back(e);
    end
  endfunction

  // one sample request, optional random idle cycle before it
  task automatic send_sample(logic signed [kpt_pkg::SampleW-1:0] s);
    if (gaps_on && $urandom_range(99) < 7) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start    <= 1'b1;
    sample_i <= s;
    do @(posedge clk_i); while (busy);
    // accepted at this edge
    loaded[load_cnt] = s;
    load_cnt++;
    if (load_cnt == VecLen) begin
      load_cnt = 0;
      transform_vector();
    end
  endtask

  // let the previous vector drain completely
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_elems.size() != 0) @(posedge clk_i);
    // per-output latency margin
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_matrix(logic [kpt_pkg::MatW-1:0] m);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= m;
    do @(posedge clk_i); while (!cfg_ready_o);
    cur_mat = m;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_random_vector();
    for (int k = 0; k < VecLen; k++) send_sample(kpt_pkg::SampleW'($urandom));
  endtask

  // directed extremes under the reset matrix
  task automatic test_reset_matrix();
    for (int k = 0; k < VecLen; k++) begin
      case (k % 6)
        0: send_sample(16'sh8000);
        1: send_sample(16'sh7FFF);
        2: send_sample(16'sh0000);
        3: send_sample(-16'sd1);
        4: send_sample(16'sd1);
        default: send_sample(kpt_pkg::SampleW'($urandom));
      endcase
    end
    wait_drained();
  endtask

  // all-max and all-min vectors under extreme matrices
  task automatic test_matrix_extremes();
    logic [kpt_pkg::MatW-1:0] mats[5];
    mats = '{MatAllTwo, MatAllOne, MatAllZeroCode, MatCleared, MatIdentity};
    foreach (mats[m]) begin
      write_matrix(mats[m]);
      for (int k = 0; k < VecLen; k++)
        send_sample((m % 2 == 0) ? 16'sh8000 : 16'sh7FFF);
      wait_drained();
    end
  endtask

  // matrix changes while a vector is partly loaded, new one applies
  task automatic test_midload_write();
    for (int k = 0; k < 10; k++) send_sample(kpt_pkg::SampleW'($urandom));
    start <= 1'b0;
    @(posedge clk_i);
    write_matrix(kpt_pkg::MatReset);
    for (int k = 10; k < VecLen; k++) send_sample(kpt_pkg::SampleW'($urandom));
    wait_drained();
  endtask

  task automatic test_random_vectors();
    for (int v = 0; v < 12; v++) begin
      // middle stretch runs without gaps
      gaps_on = !(v >= 4 && v < 9);
      if ($urandom_range(2) == 0) begin
        wait_drained();
        write_matrix(kpt_pkg::MatW'($urandom));
      end
      send_random_vector();
    end
    gaps_on = 1'b1;
  endtask

  // result checker, outputs can't be held off
  always @(posedge clk_i) begin
    element_t e;
    if (rst_ni && valid_o) begin
      if (pending_elems.size() == 0) begin
        $display("%0t: unexpected result idx %0d value %0d", $time, out_index_o, out_value_o);
        fails++;
      end else begin
        e = pending_elems.pop_front();
        if (out_index_o !== e.idx) begin
          $display("%0t: index exp %0d got %0d", $time, e.idx, out_index_o);
          fails++;
        end
        if (out_value_o !== e.value) begin
          $display("%0t: value idx %0d exp %0d got %0d", $time, e.idx, e.value, out_value_o);
          fails++;
        end
        if (last_o !== e.last) begin
          $display("%0t: last idx %0d exp %0b got %0b", $time, e.idx, e.last, last_o);
          fails++;
        end
      end
    end
  end

  initial begin
    cur_mat  = kpt_pkg::MatReset;
    load_cnt = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_matrix();
    test_matrix_extremes();
    test_midload_write();
    test_random_vectors();
    wait_drained();
    repeat (60) @(posedge clk_i);
    if (fails == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("RESULT: ERROR");
    $finish;
  end
endmodule
`default_nettype wire
